// ----- hw/rtl/rgb_led_line_encoder_defines.svh -----
// assertion macros for the led line encoder
`ifndef RGB_LED_LINE_ENCODER_DEFINES_SVH
`define RGB_LED_LINE_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent and consequent in the same cycle
`define RLLE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlle check failed");

// consequent in the cycle after the antecedent
`define RLLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlle check failed");

`else

`define RLLE_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define RLLE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/rlle_pkg.sv -----
package rlle_pkg;

    // default chain length and register reset value
    localparam int MAX_LEDS_DEF = 16;
    localparam logic [4:0] LED_COUNT_RST = 5'd16;

    // line byte codes
    localparam logic [2:0] LINE_ONE  = 3'd6;
    localparam logic [2:0] LINE_ZERO = 3'd4;

    // request codes
    typedef logic [1:0] t_req;
    localparam t_req REQ_SET   = 2'd0;
    localparam t_req REQ_CLEAR = 2'd1;
    localparam t_req REQ_SHOW  = 2'd2;

    // colour slots in wire order
    typedef logic [1:0] t_slot;
    localparam t_slot SLOT_GREEN = 2'd0;
    localparam t_slot SLOT_RED   = 2'd1;
    localparam t_slot SLOT_BLUE  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_SHOW
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic set_px;
        logic clear_px;
        logic load;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic show_nonzero;
        logic at_last;
        logic out_busy;
    } t_dp_status;

    // colour byte to eight line bytes, msb first in the lowest slot
    function automatic logic [23:0] enc_byte(input logic [7:0] c);
        logic [23:0] res;
        res = '0;
        for (int b = 0; b < 8; b++) begin
            res[3*b +: 3] = c[7-b] ? LINE_ONE : LINE_ZERO;
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/rgb_led_line_encoder.sv -----
// channel   direction  signals                        content
// request   in         s_axis_tvalid/tready/tdata/tuser  req_type, pixel index, colour
// result    out        m_axis_tvalid/tready/tdata/tuser/tlast  one encoded colour byte
// config    in         i_cfg_valid/o_cfg_ready/i_cfg_data      led_count
//
// set and unused requests are taken back to back
// a show or clear run gives 3 x led_count results (capped at MAX_LEDS), one result
// per cycle through the single output register while m_axis_tready stays high
// requests are held off for the whole run; a stalled result holds the run in place
// synchronous active-low reset: all pixels read as zero, led_count is 16, no clearing pass
`include "rgb_led_line_encoder_defines.svh"

module rgb_led_line_encoder #(
    parameter int MAX_LEDS = rlle_pkg::MAX_LEDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // pixel_index, red, green, blue
    input  logic [1:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // led_index, line_byte_0..7, zero pad
    output logic [1:0]  m_axis_tuser,   // color_slot
    output logic        m_axis_tlast,   // last_of_frame
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);
    import rlle_pkg::*;

    t_ctrl_cmd   w_cmd;
    t_dp_status  w_status;
    logic [3:0]  w_led_index;
    logic [23:0] w_line_bytes;
    logic        w_show_taken;

    assign o_cfg_ready = 1'b1;

    // request sequencing
    rlle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_type  (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_req_ready (s_axis_tready),
        .o_cmd       (w_cmd)
    );

    // pixel store, run counters and encoder
    rlle_datapath #(
        .MAX_LEDS (MAX_LEDS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_pixel_index (s_axis_tdata[7:0]),
        .i_red         (s_axis_tdata[15:8]),
        .i_green       (s_axis_tdata[23:16]),
        .i_blue        (s_axis_tdata[31:24]),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (m_axis_tready),
        .o_status      (w_status),
        .o_out_valid   (m_axis_tvalid),
        .o_led_index   (w_led_index),
        .o_color_slot  (m_axis_tuser),
        .o_line_bytes  (w_line_bytes),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, w_line_bytes, w_led_index};

    // nonempty show request taken
    assign w_show_taken = s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_SHOW)
                          && w_status.show_nonzero;

    // no request is taken while a run loads results
    `RLLE_ASSERT_SAME(a_no_req_during_run, i_clk, i_rst_n, w_cmd.load, !s_axis_tready)
    // the last result of a run always carries the blue byte
    `RLLE_ASSERT_SAME(a_last_is_blue, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser == SLOT_BLUE)
    // a nonempty show blocks the next request
    `RLLE_ASSERT_NEXT(a_show_blocks, i_clk, i_rst_n, w_show_taken, !s_axis_tready)

endmodule

// ----- hw/rtl/rlle_ctrl.sv -----
module rlle_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  rlle_pkg::t_req        i_req_type,
    input  logic                  i_out_ready,
    input  rlle_pkg::t_dp_status  i_status,
    output logic                  o_req_ready,
    output rlle_pkg::t_ctrl_cmd   o_cmd
);
    import rlle_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_accept;
    logic   w_show_req;
    logic   w_load;

    assign w_accept   = i_req_valid && (r_state == ST_IDLE);
    assign w_show_req = (i_req_type == REQ_CLEAR) || (i_req_type == REQ_SHOW);
    assign w_load     = (r_state == ST_SHOW) && (!i_status.out_busy || i_out_ready);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && w_show_req && i_status.show_nonzero) begin
                    n_state = ST_SHOW;
                end
            end
            ST_SHOW: begin
                if (w_load && i_status.at_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_req_ready    = 1'b0;
        o_cmd.set_px   = 1'b0;
        o_cmd.clear_px = 1'b0;
        o_cmd.load     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready    = 1'b1;
                o_cmd.set_px   = w_accept && (i_req_type == REQ_SET);
                o_cmd.clear_px = w_accept && (i_req_type == REQ_CLEAR);
            end
            ST_SHOW: begin
                o_cmd.load = w_load;
            end
            default: o_req_ready = 1'b0;
        endcase
    end

endmodule

// ----- hw/rtl/rlle_datapath.sv -----
module rlle_datapath #(
    parameter int MAX_LEDS = rlle_pkg::MAX_LEDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rlle_pkg::t_ctrl_cmd   i_cmd,
    input  logic [7:0]            i_pixel_index,
    input  logic [7:0]            i_red,
    input  logic [7:0]            i_green,
    input  logic [7:0]            i_blue,
    input  logic                  i_cfg_valid,
    input  logic [4:0]            i_cfg_data,
    input  logic                  i_out_ready,
    output rlle_pkg::t_dp_status  o_status,
    output logic                  o_out_valid,
    output logic [3:0]            o_led_index,
    output rlle_pkg::t_slot       o_color_slot,
    output logic [23:0]           o_line_bytes,
    output logic                  o_last
);
    import rlle_pkg::*;

    localparam int         IDX_W   = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam logic [4:0] MAX_CNT = 5'(MAX_LEDS);

    logic [23:0]         r_px_data  [MAX_LEDS];
    logic [MAX_LEDS-1:0] r_px_valid;
    logic [4:0]          r_led_count;
    logic [IDX_W-1:0]    r_led_cnt;
    t_slot               r_slot_cnt;
    logic                r_out_valid;
    logic [3:0]          r_led_index;
    t_slot               r_color_slot;
    logic [23:0]         r_line_bytes;
    logic                r_last;

    logic [4:0]          w_eff;
    logic [23:0]         w_px;
    logic [7:0]          w_color;
    logic                w_at_last;
    logic [7:0]          w_cnt_wide;

    // effective chain length, capped at the store depth
    assign w_eff = (r_led_count > MAX_CNT) ? MAX_CNT : r_led_count;

    // led count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count <= LED_COUNT_RST;
        end else if (i_cfg_valid) begin
            r_led_count <= i_cfg_data;
        end
    end

    // pixel valid bits, cleared by reset and by a clear request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_px) begin
            r_px_valid <= '0;
        end else if (i_cmd.set_px && (i_pixel_index < {3'd0, w_eff})) begin
            r_px_valid[i_pixel_index[IDX_W-1:0]] <= 1'b1;
        end
    end

    // pixel data, red in the top byte
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_px && (i_pixel_index < {3'd0, w_eff})) begin
            r_px_data[i_pixel_index[IDX_W-1:0]] <= {i_red, i_green, i_blue};
        end
    end

    // colour byte of the current slot
    assign w_px = r_px_valid[r_led_cnt] ? r_px_data[r_led_cnt] : 24'd0;
    always_comb begin
        case (r_slot_cnt)
            SLOT_GREEN: w_color = w_px[15:8];
            SLOT_RED:   w_color = w_px[23:16];
            SLOT_BLUE:  w_color = w_px[7:0];
            default:    w_color = 8'd0;
        endcase
    end

    assign w_at_last  = (r_slot_cnt == SLOT_BLUE) && ({3'd0, w_eff} == 8'(r_led_cnt) + 8'd1);
    assign w_cnt_wide = 8'(r_led_cnt);

    // run counters, back at zero after the last result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_cnt  <= '0;
            r_slot_cnt <= SLOT_GREEN;
        end else if (i_cmd.load) begin
            if (w_at_last) begin
                r_led_cnt  <= '0;
                r_slot_cnt <= SLOT_GREEN;
            end else if (r_slot_cnt == SLOT_BLUE) begin
                r_led_cnt  <= r_led_cnt + 1'b1;
                r_slot_cnt <= SLOT_GREEN;
            end else begin
                r_slot_cnt <= r_slot_cnt + 2'd1;
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_led_index  <= w_cnt_wide[3:0];
            r_color_slot <= r_slot_cnt;
            r_line_bytes <= enc_byte(w_color);
            r_last       <= w_at_last;
        end
    end

    assign o_status.show_nonzero = (w_eff != 5'd0);
    assign o_status.at_last      = w_at_last;
    assign o_status.out_busy     = r_out_valid;
    assign o_out_valid           = r_out_valid;
    assign o_led_index           = r_led_index;
    assign o_color_slot          = r_color_slot;
    assign o_line_bytes          = r_line_bytes;
    assign o_last                = r_last;

endmodule

// ----- test/tb_top.sv -----
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rlle_pkg::*;

    localparam int MAX_PIXELS     = MAX_LEDS_DEF;
    localparam t_req REQ_UNUSED   = 2'd3;
    localparam int IDLE_SETTLE    = 10;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PER_RUN = 28;

    // one request as it travels on the slave side
    typedef struct packed {
        t_req       kind;
        logic [7:0] idx;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel_req;

    // one encoded color byte as it should leave the block
    typedef struct packed {
        logic [3:0]      led;
        t_slot           slot;
        logic [7:0][2:0] line;
        logic            last;
    } t_line_code;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_data = '0;

    // pending requests, predicted line codes and the shadow of the block state
    t_pixel_req  request_q[$];
    t_line_code  line_code_q[$];
    logic [23:0] pixel_colors[MAX_PIXELS];
    logic [4:0]  led_count_copy = LED_COUNT_RST;
    t_pixel_req  req_on_bus;

    int mismatches = 0;
    int requests_pushed = 0;
    int requests_taken = 0;
    int shows_run = 0;
    int results_seen = 0;
    int cfg_writes = 0;
    int idle_cycles = 0;
    int tx_gap = 0;
    int tx_calm = 0;
    int rx_stall = 0;
    int rx_calm = 0;
    int hold_left = 0;
    logic hold_armed = 1'b0;
    logic hold_done = 1'b0;

    rgb_led_line_encoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // chain length actually in use
    function automatic int active_leds();
        return (led_count_copy > MAX_PIXELS) ? MAX_PIXELS : int'(led_count_copy);
    endfunction

    // mostly no gap, some short ones, a few long ones, and calm stretches
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // update the pixel shadow and predict the line codes of one request
    function automatic void encode_request(input t_pixel_req req);
        int leds;
        logic [23:0] px;
        logic [7:0] c;
        t_line_code code;
        leds = active_leds();
        requests_taken++;
        if (req.kind == REQ_SET) begin
            if (req.idx < leds) pixel_colors[req.idx] = {req.red, req.green, req.blue};
            return;
        end
        if (req.kind == REQ_UNUSED) return;
        if (req.kind == REQ_CLEAR) begin
            foreach (pixel_colors[i]) pixel_colors[i] = '0;
        end
        shows_run++;
        for (int led = 0; led < leds; led++) begin
            px = pixel_colors[led];
            for (int s = 0; s < 3; s++) begin
                code.led = led[3:0];
                code.slot = t_slot'(s);
                case (code.slot)
                    SLOT_GREEN: c = px[15:8];
                    SLOT_RED:   c = px[23:16];
                    default:    c = px[7:0];
                endcase
                // msb of the color goes out first
                for (int b = 0; b < 8; b++) begin
                    code.line[b] = c[7-b] ? LINE_ONE : LINE_ZERO;
                end
                code.last = (led == leds - 1) && (code.slot == SLOT_BLUE);
                line_code_q.push_back(code);
            end
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    // request driver
    always @(posedge i_clk) begin : drive_requests
        logic busy;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            busy = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                encode_request(req_on_bus);
                busy = 1'b0;
                tx_gap = pick_gap(tx_calm);
            end
            if (!busy) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (request_q.size() > 0) begin
                    req_on_bus = request_q.pop_front();
                    s_axis_tdata <= {req_on_bus.blue, req_on_bus.green, req_on_bus.red,
                                     req_on_bus.idx};
                    s_axis_tuser <= req_on_bus.kind;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin : watch_results
        t_line_code want;
        logic took;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            took = m_axis_tvalid && m_axis_tready;
            if (took) begin
                results_seen++;
                if (line_code_q.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: unexpected result, expected none actual %h/%0d/%0d",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end else begin
                    want = line_code_q.pop_front();
                    check_field("led_index", want.led, m_axis_tdata[3:0]);
                    check_field("color_slot", want.slot, m_axis_tuser);
                    for (int b = 0; b < 8; b++) begin
                        check_field($sformatf("line_byte_%0d", b), want.line[b],
                                    m_axis_tdata[4+3*b +: 3]);
                    end
                    check_field("last_of_frame", want.last, m_axis_tlast);
                end
                rx_stall = pick_gap(rx_calm);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_armed && !hold_done && m_axis_tvalid) begin
                // long hold-off while a run is under way so the request side backs up
                hold_left = LONG_HOLD - 1;
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on any handshake
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: timeout, no handshake for %0d cycles", $time, idle_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic push_req(input t_req kind, input int idx, input int red,
                            input int green, input int blue);
        t_pixel_req req;
        req.kind = kind;
        req.idx = idx[7:0];
        req.red = red[7:0];
        req.green = green[7:0];
        req.blue = blue[7:0];
        request_q.push_back(req);
        requests_pushed++;
    endtask

    // all requests taken, all results back, then let a trailing set settle
    task automatic wait_idle();
        do @(posedge i_clk);
        while (requests_taken < requests_pushed || line_code_q.size() > 0);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_led_count(input logic [4:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        led_count_copy = value;
        cfg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    // random requests, mostly in-range sets with shows in between
    task automatic random_run(input logic [4:0] value, input int n);
        int leds;
        int r;
        int idx;
        write_led_count(value);
        leds = active_leds();
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                if (leds > 0 && $urandom_range(0, 99) < 80) idx = $urandom_range(0, leds - 1);
                else idx = $urandom_range(0, 255);
                push_req(REQ_SET, idx, $urandom, $urandom, $urandom);
            end else if (r < 85) begin
                push_req(REQ_SHOW, $urandom, $urandom, $urandom, $urandom);
            end else if (r < 92) begin
                push_req(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom);
            end else begin
                push_req(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom);
            end
        end
        wait_idle();
    endtask

    initial begin : run_test
        // the store comes out of reset all zero
        foreach (pixel_colors[i]) pixel_colors[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full chain at reset length: extremes, out of range indexes, unused code
        push_req(REQ_SET, 0, 8'hff, 8'hff, 8'hff);
        push_req(REQ_SET, 15, 8'h80, 8'h01, 8'h5a);
        push_req(REQ_SET, 7, 8'haa, 8'h55, 8'h0f);
        push_req(REQ_SET, 16, 8'hff, 8'hff, 8'hff);
        push_req(REQ_SET, 255, 8'h12, 8'h34, 8'h56);
        push_req(REQ_UNUSED, 1, 8'hff, 8'hff, 8'hff);
        push_req(REQ_SHOW, 0, 0, 0, 0);
        push_req(REQ_CLEAR, 255, 8'hff, 8'hff, 8'hff);
        push_req(REQ_SET, 3, 8'hc3, 8'h3c, 8'hf0);
        push_req(REQ_SHOW, 0, 0, 0, 0);
        wait_idle();

        // empty chain: sets ignored, shows silent, clear still wipes the store
        write_led_count(5'd0);
        push_req(REQ_SET, 0, 8'hff, 8'hff, 8'hff);
        push_req(REQ_SHOW, 0, 0, 0, 0);
        push_req(REQ_CLEAR, 0, 0, 0, 0);
        wait_idle();

        // single led
        write_led_count(5'd1);
        push_req(REQ_SHOW, 0, 0, 0, 0);
        push_req(REQ_SET, 0, 8'h01, 8'h80, 8'h7e);
        push_req(REQ_SET, 1, 8'hff, 8'hff, 8'hff);
        push_req(REQ_SHOW, 0, 0, 0, 0);
        wait_idle();

        // count above the store size acts as the full chain
        write_led_count(5'd31);
        push_req(REQ_SHOW, 0, 0, 0, 0);
        push_req(REQ_SET, 15, 8'hff, 8'h00, 8'hff);
        push_req(REQ_SHOW, 0, 0, 0, 0);
        wait_idle();

        // random runs over several chain lengths, long hold-off in the first
        hold_armed <= 1'b1;
        random_run(5'd16, RANDOM_PER_RUN);
        random_run(5'($urandom_range(17, 31)), RANDOM_PER_RUN);
        random_run(5'($urandom_range(2, 15)), RANDOM_PER_RUN);
        random_run(5'd1, RANDOM_PER_RUN);
        repeat (IDLE_SETTLE) @(posedge i_clk);

        $display("covered %0d requests with %0d show runs, %0d line codes checked",
                 requests_taken, shows_run, results_seen);
        $display("led_count written %0d times, long receiver hold-off %s",
                 cfg_writes, hold_done ? "done" : "not reached");
        if (mismatches == 0 && line_code_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
